### rtl/core/lfu_pkg.sv
`default_nettype none
package lfu_pkg;
  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned CAP_W          = 5;

  // operation codes carried on the mode field
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_VICTIM = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear_scan;
    logic scan_step;
    logic do_update;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic found;
    logic need_victim;
  } dp_sts_t;
endpackage
`default_nettype wire

### rtl/core/lfu_ctrl.sv
`default_nettype none
module lfu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output logic                  done,
  output lfu_pkg::dp_cmd_t      cmd,
  input  wire lfu_pkg::dp_sts_t sts
);
  import lfu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load       = 1'b1;
          cmd.clear_scan = 1'b1;
          state_nxt      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          cmd.clear_scan = 1'b1;
          state_nxt = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        // the lookup result is complete here; skip the search when not needed
        if (sts.found || !sts.need_victim) begin
          state_nxt = ST_UPDATE;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.do_update = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_DONE);

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_LOOKUP))
    else $error("start not taken");
  a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (state_r == ST_IDLE))
    else $error("done held");
  a_update_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> (state_r == ST_DONE))
    else $error("update not followed by done");
endmodule
`default_nettype wire

### rtl/core/lfu_dp.sv
`default_nettype none
module lfu_dp #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lfu_pkg::dp_cmd_t            cmd,
  output lfu_pkg::dp_sts_t                 sts,
  input  wire logic                        cfg_we,
  input  wire logic [lfu_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire logic                        in_mode,
  input  wire logic signed [31:0]          in_key,
  input  wire logic signed [31:0]          in_value,
  input  wire logic                        done,
  output logic                             out_hit,
  output logic signed [31:0]               out_read_value,
  output logic                             out_evicted,
  output logic signed [31:0]               out_evicted_key
);
  import lfu_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // per-entry storage; valid bits cleared on reset, rest undefined until written
  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_W-1:0]      key_r   [ENTRIES];
  logic [KEY_W-1:0]      data_r  [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_r   [ENTRIES];
  logic [IW-1:0]         rank_r  [ENTRIES];
  logic [OW-1:0]         occ_r;
  logic [CAP_W-1:0]      cap_r;

  // item registers
  logic                  mode_r;
  logic [KEY_W-1:0]      ikey_r, ival_r;
  logic [IW-1:0]         idx_r;
  logic                  found_r;
  logic [IW-1:0]         slot_r;
  logic                  have_r;
  logic [IW-1:0]         vic_r;
  logic                  free_ok_r;
  logic [IW-1:0]         free_r;
  logic                  res_hit_r, res_ev_r;
  logic [KEY_W-1:0]      res_rd_r, res_evk_r;

  logic [OW-1:0]         cap_eff;
  logic                  full;
  logic                  scan_last;

  always_comb begin
    if (int'(cap_r) > int'(ENTRIES))
      cap_eff = OW'(ENTRIES);
    else
      cap_eff = OW'(cap_r);
  end
  assign full      = (occ_r >= cap_eff);
  assign scan_last = (idx_r == IW'(ENTRIES - 1));

  assign sts.scan_last   = scan_last;
  assign sts.found       = found_r;
  assign sts.need_victim = (mode_r == MODE_PUT) && (cap_eff != '0) && full;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_W'(ENTRIES_DEF);
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  // lookup / victim scan, one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      ikey_r    <= in_key;
      ival_r    <= in_value;
      found_r   <= 1'b0;
      slot_r    <= '0;
      have_r    <= 1'b0;
      vic_r     <= '0;
      free_ok_r <= 1'b0;
      free_r    <= '0;
    end else if (cmd.scan_step) begin
      if (!found_r && valid_r[idx_r] && key_r[idx_r] == ikey_r) begin
        found_r <= 1'b1;
        slot_r  <= idx_r;
      end
      if (!valid_r[idx_r] && !free_ok_r) begin
        free_ok_r <= 1'b1;
        free_r    <= idx_r;
      end
      if (valid_r[idx_r] && (!have_r || cnt_r[idx_r] < cnt_r[vic_r] ||
          (cnt_r[idx_r] == cnt_r[vic_r] && rank_r[idx_r] > rank_r[vic_r]))) begin
        have_r <= 1'b1;
        vic_r  <= idx_r;
      end
    end
    if (cmd.clear_scan)     idx_r <= '0;
    else if (cmd.scan_step) idx_r <= scan_last ? '0 : idx_r + 1'b1;
  end

  // update: all entries at once (independent per-entry logic)
  logic          do_hit, do_ins, do_ev;
  logic [IW-1:0] ins_slot;
  logic [IW-1:0] rref;
  always_comb begin
    do_hit   = found_r;
    do_ev    = !found_r && sts.need_victim && have_r;
    // after eviction the first free slot is the lowest of free_r and vic_r
    ins_slot = free_r;
    if (do_ev && (!free_ok_r || vic_r < free_r)) ins_slot = vic_r;
    do_ins   = !found_r && (mode_r == MODE_PUT) && (cap_eff != '0) && (free_ok_r || do_ev);
    rref     = do_hit ? rank_r[slot_r] : rank_r[vic_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (cmd.do_update) begin
      if (do_ev) valid_r[vic_r] <= 1'b0;
      if (do_ins) valid_r[ins_slot] <= 1'b1;
      if (do_ins && !do_ev) occ_r <= occ_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i]) begin
          if (do_hit) begin
            if (IW'(i) != slot_r && rank_r[i] < rref) rank_r[i] <= rank_r[i] + 1'b1;
          end else if (do_ins && !(do_ev && IW'(i) == vic_r)) begin
            // eviction closes the gap, insertion ages everyone by one
            if (do_ev && rank_r[i] > rref) rank_r[i] <= rank_r[i];
            else rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
      end
      if (do_hit) begin
        rank_r[slot_r] <= '0;
        if (cnt_r[slot_r] != CNT_MAX) cnt_r[slot_r] <= cnt_r[slot_r] + 1'b1;
        if (mode_r == MODE_PUT) data_r[slot_r] <= ival_r;
      end else if (do_ins) begin
        rank_r[ins_slot] <= '0;
        cnt_r[ins_slot]  <= COUNT_BITS'(1);
        key_r[ins_slot]  <= ikey_r;
        data_r[ins_slot] <= ival_r;
      end
      res_hit_r <= do_hit;
      res_rd_r  <= (do_hit && mode_r == MODE_GET) ? data_r[slot_r] : '0;
      res_ev_r  <= do_ev;
      res_evk_r <= do_ev ? key_r[vic_r] : '0;
    end
  end

  assign out_hit         = done & res_hit_r;
  assign out_read_value  = done ? res_rd_r : '0;
  assign out_evicted     = done & res_ev_r;
  assign out_evicted_key = done ? res_evk_r : '0;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(ENTRIES))
    else $error("occupancy over size");
  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy mismatch");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_update |-> !(do_hit && do_ev))
    else $error("hit with eviction");
endmodule
`default_nettype wire

### rtl/core/lfu_cache_lookup_update_top.sv
`default_nettype none
// channel   ports                                      handshake
// config    cfg_we, cfg_wdata[4:0]                     write when cfg_we
// input     in_mode, in_key, in_value                  beat when start && !busy
// result    out_hit, out_read_value, out_evicted,      beat when done (one cycle)
//           out_evicted_key
//
// the input beat is followed by the lookup scan over all ENTRIES entries, a decision state,
// an update state and the result state, which carries the result beat
// a put miss on a full store with nonzero capacity runs a second scan over all ENTRIES
// entries in the decision state, the victim pass, before the update
// busy drops in the cycle after the result beat, so a new item is taken only after
// the previous one has completed
// rst_n is synchronous: clears valid bits, occupancy, capacity to 16 and the fsm
// the receiver cannot stall; busy stays high through the result beat
module lfu_cache_lookup_update_top #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_mode,
  input  wire logic signed [31:0]        in_key,
  input  wire logic signed [31:0]        in_value,
  output logic                           done,
  output logic                           out_hit,
  output logic signed [31:0]             out_read_value,
  output logic                           out_evicted,
  output logic signed [31:0]             out_evicted_key
);
  import lfu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle, lookup scan, victim scan, update, result
  lfu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  // entry store, scan registers and result registers
  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_value        (in_value),
    .done            (done),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import lfu_pkg::*;

  localparam int unsigned NSLOT = ENTRIES_DEF;
  localparam int unsigned CMAX = (1 << COUNT_BITS_DEF) - 1;

  // result beat as seen on the ports
  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic signed [31:0] in_key = '0;
  logic signed [31:0] in_value = '0;
  logic done;
  logic out_hit;
  logic signed [31:0] out_read_value;
  logic out_evicted;
  logic signed [31:0] out_evicted_key;

  always #1 clk = ~clk;

  lfu_cache_lookup_update_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_key(in_key), .in_value(in_value),
    .done(done), .out_hit(out_hit), .out_read_value(out_read_value),
    .out_evicted(out_evicted), .out_evicted_key(out_evicted_key)
  );

  // shadow copy of the cache contents
  logic        sh_valid [NSLOT];
  logic [31:0] sh_key   [NSLOT];
  logic [31:0] sh_data  [NSLOT];
  int unsigned sh_count [NSLOT];
  int unsigned sh_rank  [NSLOT];
  int unsigned sh_occ;
  int unsigned sh_cap;

  lookup_res_t pending_q[$];
  int unsigned err_cnt = 0;
  int unsigned idle_pct = 0;
  logic [31:0] key_pool[8];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // move slot to most recent, bump its use count
  function automatic void promote_slot(input int unsigned s);
    int unsigned r;
    r = sh_rank[s];
    for (int i = 0; i < NSLOT; i++)
      if (sh_valid[i] && i != s && sh_rank[i] < r) sh_rank[i]++;
    sh_rank[s] = 0;
    if (sh_count[s] < CMAX) sh_count[s]++;
  endfunction

  function automatic lookup_res_t predict_lookup(input logic m, input logic [31:0] k,
                                                 input logic [31:0] v);
    lookup_res_t res;
    int unsigned cap, slot, vic, r;
    bit found, have;
    res = '0;
    cap = (sh_cap > NSLOT) ? NSLOT : sh_cap;
    found = 0;
    slot = 0;
    for (int i = 0; i < NSLOT; i++)
      if (!found && sh_valid[i] && sh_key[i] == k) begin
        slot = i;
        found = 1;
      end
    if (found) begin
      res.hit = 1'b1;
      promote_slot(slot);
      if (m == MODE_GET) res.read_value = sh_data[slot];
      else sh_data[slot] = v;
    end else if (m == MODE_PUT && cap != 0) begin
      if (sh_occ >= cap) begin
        have = 0;
        vic = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (!sh_valid[i]) continue;
          if (!have || sh_count[i] < sh_count[vic] ||
              (sh_count[i] == sh_count[vic] && sh_rank[i] > sh_rank[vic])) begin
            vic = i;
            have = 1;
          end
        end
        if (have) begin
          res.evicted = 1'b1;
          res.evicted_key = sh_key[vic];
          r = sh_rank[vic];
          sh_valid[vic] = 1'b0;
          for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && sh_rank[i] > r) sh_rank[i]--;
          if (sh_occ > 0) sh_occ--;
        end
      end
      for (int i = 0; i < NSLOT; i++)
        if (!found && !sh_valid[i]) begin
          slot = i;
          found = 1;
        end
      if (found) begin
        for (int j = 0; j < NSLOT; j++)
          if (sh_valid[j]) sh_rank[j]++;
        sh_valid[slot] = 1'b1;
        sh_key[slot] = k;
        sh_data[slot] = v;
        sh_count[slot] = 1;
        sh_rank[slot] = 0;
        sh_occ++;
      end
    end
    return res;
  endfunction

  // one beat into the block, with optional random idle first
  task automatic send_op(input logic m, input logic [31:0] k, input logic [31:0] v);
    do @(negedge clk); while ($urandom_range(99) < idle_pct);
    start <= 1'b1;
    in_mode <= m;
    in_key <= k;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(predict_lookup(m, k, v));
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (2 * NSLOT + 8) @(negedge clk);
  endtask

  task automatic write_capacity(input int unsigned c);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= c[CAP_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    sh_cap = c;
  endtask

  // result checker: done is a single-cycle strobe
  always @(posedge clk) begin
    lookup_res_t exp_r;
    if (rst_n && done) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", 32'(done), 32'(1'b0));
      end else begin
        exp_r = pending_q.pop_front();
        if (out_hit !== exp_r.hit) report_mismatch("hit", 32'(out_hit), 32'(exp_r.hit));
        if (out_read_value !== exp_r.read_value)
          report_mismatch("read_value", out_read_value, exp_r.read_value);
        if (out_evicted !== exp_r.evicted)
          report_mismatch("evicted", 32'(out_evicted), 32'(exp_r.evicted));
        if (out_evicted_key !== exp_r.evicted_key)
          report_mismatch("evicted_key", out_evicted_key, exp_r.evicted_key);
      end
    end
  end

  // field extremes, get and put, hit and miss, eviction and ties
  task automatic test_directed();
    send_op(MODE_GET, 32'h0, 32'h0);
    send_op(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_op(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_op(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_op(MODE_GET, 32'h8000_0000, 32'h1234_5678);
    send_op(MODE_PUT, 32'h7fff_ffff, 32'h0);
    send_op(MODE_GET, 32'h7fff_ffff, 32'h0);
    // small capacity forces eviction with count ties broken by age
    write_capacity(2);
    send_op(MODE_PUT, 32'h11, 32'h1);
    send_op(MODE_PUT, 32'h22, 32'h2);
    send_op(MODE_GET, 32'h11, 32'h0);
    send_op(MODE_PUT, 32'h33, 32'h3);
    send_op(MODE_PUT, 32'h44, 32'h4);
    // capacity zero: misses do nothing, hits on old entries still update
    write_capacity(0);
    send_op(MODE_PUT, 32'h55, 32'h5);
    send_op(MODE_PUT, 32'h11, 32'h99);
    send_op(MODE_GET, 32'h11, 32'h0);
    // capacity above the built size
    write_capacity(31);
    for (int i = 0; i < 4; i++) send_op(MODE_PUT, 32'h100 + i, i);
  endtask

  // two hot keys with many hits each, then evictions between counted entries
  task automatic test_hot_keys();
    write_capacity(2);
    idle_pct = 0;
    send_op(MODE_PUT, 32'hA, 32'h1);
    send_op(MODE_PUT, 32'hB, 32'h2);
    for (int i = 0; i < 40; i++) send_op(MODE_GET, (i & 1) ? 32'hA : 32'hB, 32'h0);
    send_op(MODE_PUT, 32'hC, 32'h3);
    send_op(MODE_PUT, 32'hD, 32'h4);
  endtask

  task automatic test_random();
    int unsigned caps[6] = '{16, 1, 4, 0, 9, 16};
    int unsigned pcts[4] = '{0, 62, 27, 62};
    logic [31:0] k;
    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      for (int n = 0; n < 260; n++) begin
        idle_pct = pcts[(n / 65) % 4];
        if ($urandom_range(9) < 8) k = key_pool[$urandom_range(7)] ^ $urandom_range(3);
        else k = $urandom;
        send_op(1'($urandom_range(1)), k, $urandom);
        // sender holds off until the pipe is empty
        if (n == 130) while (pending_q.size() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0;
      sh_data[i] = '0;
      sh_count[i] = 0;
      sh_rank[i] = 0;
    end
    sh_occ = 0;
    sh_cap = 16;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    test_hot_keys();
    wait_drained();
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
